[hw/rtl/lnig_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lnig_pkg
// Shared types and constants of the lattice neighbour index generator.
// ---------------------------------------------------------------------------
package lnig_pkg;

  localparam int IDX_W          = 24;  // node index width
  localparam int AXIS_W         = 9;   // nodes-across register width
  localparam int PLANE_W        = 2 * AXIS_W;
  localparam int CFG_IDX_W      = 3;
  localparam int MASK_W         = 27;  // 3x3x3 offset cube, center included
  localparam int MASK_IDX_W     = 5;
  localparam int DIV_CYCLES     = IDX_W / 2;  // two quotient bits a cycle
  localparam int DIV_CNT_W      = $clog2(DIV_CYCLES);
  localparam int MAX_ACROSS_DEF = 256;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NX   = 3'd0,
    REG_NY   = 3'd1,
    REG_NZ   = 3'd2,
    REG_DIMS = 3'd3,
    REG_KIND = 3'd4
  } cfg_reg_t;

  localparam logic [1:0] DIMS_3D = 2'd3;

  typedef enum logic [1:0] {
    ST_NEIGHBOUR = 2'd0,
    ST_LONE      = 2'd1,
    ST_PAST      = 2'd2
  } status_t;

  // effective lattice shape, axes already clamped
  typedef struct packed {
    logic [AXIS_W-1:0] nx;
    logic [AXIS_W-1:0] ny;
    logic [AXIS_W-1:0] nz;  // 1 in 2D
    logic              three;
    logic              von;
  } cfg_t;

  // one classified node on its way from front to back
  typedef struct packed {
    logic [IDX_W-1:0]  node;
    logic [MASK_W-1:0] mask;
    status_t           status;
  } entry_t;

endpackage

[hw/rtl/lattice_neighbour_index_generator_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lattice_neighbour_index_generator_unit
// Lists the neighbour indexes of one node of a row-major 2D or 3D lattice.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready, node_id): one node index per
//   transfer. Output channel (out_valid/out_ready): one result per transfer,
//   neighbour_index plus status, is_last set on the final result of a node.
//   Neighbours leave in ascending index order; a node with no neighbours
//   gives one status-1 result, an index past the lattice one status-2 result.
//   Configuration: cfg_we writes cfg_data into register cfg_index
//   (0 nx, 1 ny, 2 nz, 3 dimensions, 4 neighbourhood kind); write only idle.
// Flow:
//   The front splits the index into x, y, z with a divider that retires two
//   quotient bits a cycle: first x, then y and z, then a push state that
//   also loads the next node, so a busy front starts a new node as it pushes
//   the last. The back emits one result per cycle while the receiver is
//   ready, 1 to 26 per node. An input holding register and a two-entry
//   queue let the front keep working while the back or the receiver stalls;
//   a stalled receiver holds the registered output steady and backs up to
//   in_ready.
// Reset: rst (synchronous) empties all stages and restores nx=ny=nz=1,
//   2D, Moore neighbourhood.
// ---------------------------------------------------------------------------
module lattice_neighbour_index_generator_unit #(
  parameter int MAX_ACROSS = lnig_pkg::MAX_ACROSS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [lnig_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [lnig_pkg::AXIS_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [lnig_pkg::IDX_W-1:0]     node_id,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [lnig_pkg::IDX_W-1:0]     neighbour_index,
  output logic [1:0]                     status,
  output logic                           is_last
);

  // raw configuration registers
  logic [lnig_pkg::AXIS_W-1:0] nodes_across_x;
  logic [lnig_pkg::AXIS_W-1:0] nodes_across_y;
  logic [lnig_pkg::AXIS_W-1:0] nodes_across_z;
  logic [1:0]                  dimensions;
  logic                        neighbourhood_kind;

  lnig_pkg::cfg_t   cfg;
  logic             q_wr_valid, q_wr_ready;
  logic             q_rd_valid, q_rd_ready;
  lnig_pkg::entry_t q_wr_entry, q_rd_entry;

  // zero acts as one, anything above MAX_ACROSS as MAX_ACROSS
  function automatic logic [lnig_pkg::AXIS_W-1:0] clamp_axis(
    input logic [lnig_pkg::AXIS_W-1:0] v
  );
    logic [lnig_pkg::AXIS_W-1:0] r;
    if (v == '0) begin
      r = lnig_pkg::AXIS_W'(1);
    end else if (int'(v) > MAX_ACROSS) begin
      r = lnig_pkg::AXIS_W'(MAX_ACROSS);
    end else begin
      r = v;
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      nodes_across_x     <= lnig_pkg::AXIS_W'(1);
      nodes_across_y     <= lnig_pkg::AXIS_W'(1);
      nodes_across_z     <= lnig_pkg::AXIS_W'(1);
      dimensions         <= 2'd2;
      neighbourhood_kind <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        lnig_pkg::REG_NX:   nodes_across_x     <= cfg_data;
        lnig_pkg::REG_NY:   nodes_across_y     <= cfg_data;
        lnig_pkg::REG_NZ:   nodes_across_z     <= cfg_data;
        lnig_pkg::REG_DIMS: dimensions         <= cfg_data[1:0];
        lnig_pkg::REG_KIND: neighbourhood_kind <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // effective shape; any dimension count other than 3 means 2D
  always_comb begin
    cfg.three = (dimensions == lnig_pkg::DIMS_3D);
    cfg.von   = neighbourhood_kind;
    cfg.nx    = clamp_axis(nodes_across_x);
    cfg.ny    = clamp_axis(nodes_across_y);
    cfg.nz    = cfg.three ? clamp_axis(nodes_across_z) : lnig_pkg::AXIS_W'(1);
  end

  lnig_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .node_id    (node_id),
    .cfg        (cfg),
    .q_valid    (q_wr_valid),
    .q_ready    (q_wr_ready),
    .q_entry    (q_wr_entry)
  );

  lnig_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (q_wr_valid),
    .wr_ready (q_wr_ready),
    .wr_entry (q_wr_entry),
    .rd_valid (q_rd_valid),
    .rd_ready (q_rd_ready),
    .rd_entry (q_rd_entry)
  );

  lnig_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .q_valid         (q_rd_valid),
    .q_ready         (q_rd_ready),
    .q_entry         (q_rd_entry),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .neighbour_index (neighbour_index),
    .status          (status),
    .is_last         (is_last)
  );

endmodule

[hw/rtl/lnig_front.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lnig_front
// Accepts node indexes, splits them into x, y, z with a shared radix-4
// divider and builds the mask of neighbours that lie inside the lattice.
// ---------------------------------------------------------------------------
module lnig_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [lnig_pkg::IDX_W-1:0] node_id,
  input  lnig_pkg::cfg_t        cfg,
  output logic                  q_valid,
  input  logic                  q_ready,
  output lnig_pkg::entry_t      q_entry
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV_X,
    S_DIV_Y,
    S_PUSH
  } state_t;

  state_t                            state;
  logic                              hold_valid;
  logic [lnig_pkg::IDX_W-1:0]        hold_node;
  logic [lnig_pkg::IDX_W-1:0]        node_r;
  logic [lnig_pkg::IDX_W-1:0]        dvd;   // dividend in, quotient out
  logic [lnig_pkg::AXIS_W-1:0]       rem;
  logic [lnig_pkg::AXIS_W-1:0]       x_r;
  logic [lnig_pkg::DIV_CNT_W-1:0]    cnt;

  logic [lnig_pkg::IDX_W-1:0]        dvd_next;
  logic [lnig_pkg::AXIS_W-1:0]       rem_next;
  logic [lnig_pkg::AXIS_W-1:0]       divisor;
  logic [lnig_pkg::AXIS_W:0]         part;
  logic                              ge;
  logic                              start;
  logic                              pushed;
  logic [2:0]                        okx, oky, okz;
  logic [lnig_pkg::MASK_W-1:0]       mask;
  logic                              past;

  // two restoring division steps per cycle
  always_comb begin
    divisor  = (state == S_DIV_Y) ? cfg.ny : cfg.nx;
    dvd_next = dvd;
    rem_next = rem;
    part     = '0;
    ge       = 1'b0;
    for (int i = 0; i < 2; i++) begin
      part     = {rem_next, dvd_next[lnig_pkg::IDX_W-1]};
      ge       = part >= {1'b0, divisor};
      rem_next = ge ? lnig_pkg::AXIS_W'(part - {1'b0, divisor})
                    : part[lnig_pkg::AXIS_W-1:0];
      dvd_next = {dvd_next[lnig_pkg::IDX_W-2:0], ge};
    end
  end

  // classification, valid in S_PUSH: x in x_r, y in rem, z in dvd
  always_comb begin
    int nzc;
    okx[0] = (x_r != '0);
    okx[1] = 1'b1;
    okx[2] = ({1'b0, x_r} + 1'b1) < {1'b0, cfg.nx};
    oky[0] = (rem != '0);
    oky[1] = 1'b1;
    oky[2] = ({1'b0, rem} + 1'b1) < {1'b0, cfg.ny};
    okz[0] = cfg.three && (dvd != '0);
    okz[1] = 1'b1;
    okz[2] = cfg.three &&
             (({1'b0, dvd} + 1'b1) < (lnig_pkg::IDX_W + 1)'(cfg.nz));
    past   = dvd >= lnig_pkg::IDX_W'(cfg.nz);
    mask   = '0;
    for (int dz = 0; dz < 3; dz++) begin
      for (int dy = 0; dy < 3; dy++) begin
        for (int dx = 0; dx < 3; dx++) begin
          nzc = int'(dx != 1) + int'(dy != 1) + int'(dz != 1);
          mask[dz * 9 + dy * 3 + dx] = okx[dx] && oky[dy] && okz[dz] &&
                                       (nzc != 0) && (!cfg.von || nzc == 1);
        end
      end
    end
  end

  always_comb begin
    q_entry.node = node_r;
    q_entry.mask = mask;
    if (past) begin
      q_entry.status = lnig_pkg::ST_PAST;
    end else if (mask == '0) begin
      q_entry.status = lnig_pkg::ST_LONE;
    end else begin
      q_entry.status = lnig_pkg::ST_NEIGHBOUR;
    end
  end

  assign q_valid  = (state == S_PUSH);
  assign pushed   = q_valid && q_ready;
  assign in_ready = !hold_valid;
  assign start    = hold_valid && (state == S_IDLE || pushed);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      hold_valid <= 1'b0;
      cnt        <= '0;
    end else begin
      if (in_valid && in_ready) begin
        hold_valid <= 1'b1;
        hold_node  <= node_id;
      end else if (start) begin
        hold_valid <= 1'b0;
      end
      case (state)
        S_IDLE, S_PUSH: begin
          if (start) begin
            state  <= S_DIV_X;
            node_r <= hold_node;
            dvd    <= hold_node;
            rem    <= '0;
            cnt    <= '0;
          end else if (pushed) begin
            state <= S_IDLE;
          end
        end
        S_DIV_X: begin
          dvd <= dvd_next;
          cnt <= cnt + 1'b1;
          if (cnt == lnig_pkg::DIV_CNT_W'(lnig_pkg::DIV_CYCLES - 1)) begin
            state <= S_DIV_Y;
            x_r   <= rem_next;
            rem   <= '0;
            cnt   <= '0;
          end else begin
            rem <= rem_next;
          end
        end
        S_DIV_Y: begin
          dvd <= dvd_next;
          rem <= rem_next;
          cnt <= cnt + 1'b1;
          if (cnt == lnig_pkg::DIV_CNT_W'(lnig_pkg::DIV_CYCLES - 1)) begin
            state <= S_PUSH;
            cnt   <= '0;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[hw/rtl/lnig_queue.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lnig_queue
// Two-entry queue between front and back.
// ---------------------------------------------------------------------------
module lnig_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  lnig_pkg::entry_t wr_entry,
  output logic             rd_valid,
  input  logic             rd_ready,
  output lnig_pkg::entry_t rd_entry
);

  lnig_pkg::entry_t slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       fill;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_entry = slots[rd_ptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_wr) begin
        slots[wr_ptr] <= wr_entry;
        wr_ptr        <= !wr_ptr;
      end
      if (do_rd) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_wr && !do_rd) begin
        fill <= fill + 2'd1;
      end else if (do_rd && !do_wr) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

[hw/rtl/lnig_back.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lnig_back
// Walks the neighbour mask lowest offset first and emits one index a
// cycle through a registered output stage while the receiver is ready.
// ---------------------------------------------------------------------------
module lnig_back (
  input  logic                        clk,
  input  logic                        rst,
  input  lnig_pkg::cfg_t              cfg,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  lnig_pkg::entry_t            q_entry,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [lnig_pkg::IDX_W-1:0]  neighbour_index,
  output logic [1:0]                  status,
  output logic                        is_last
);

  logic                               cur_valid;
  lnig_pkg::entry_t                   cur;
  logic [lnig_pkg::PLANE_W-1:0]       plane;
  logic [lnig_pkg::MASK_W-1:0]        mask_next;
  logic [1:0]                         sdx, sdy, sdz;
  logic [lnig_pkg::IDX_W-1:0]         tx, ty, tz;
  logic [lnig_pkg::IDX_W-1:0]         idx;
  logic                               last;
  logic                               load;
  logic                               done;

  // lowest set offset; offsets ordered dz, dy, dx so indexes ascend
  always_comb begin
    sdx = 2'd1;
    sdy = 2'd1;
    sdz = 2'd1;
    for (int k = lnig_pkg::MASK_W - 1; k >= 0; k--) begin
      if (cur.mask[k]) begin
        sdx = 2'(k % 3);
        sdy = 2'((k / 3) % 3);
        sdz = 2'(k / 9);
      end
    end
    mask_next = cur.mask & (cur.mask - 1'b1);
  end

  // index arithmetic wraps at 24 bits; true result always fits
  always_comb begin
    tx = (sdx == 2'd0) ? '1 : lnig_pkg::IDX_W'(sdx == 2'd2);
    case (sdy)
      2'd0:    ty = lnig_pkg::IDX_W'(0) - lnig_pkg::IDX_W'(cfg.nx);
      2'd2:    ty = lnig_pkg::IDX_W'(cfg.nx);
      default: ty = '0;
    endcase
    case (sdz)
      2'd0:    tz = lnig_pkg::IDX_W'(0) - lnig_pkg::IDX_W'(plane);
      2'd2:    tz = lnig_pkg::IDX_W'(plane);
      default: tz = '0;
    endcase
    idx  = cur.node + tx + ty + tz;
    last = (cur.status != lnig_pkg::ST_NEIGHBOUR) || (mask_next == '0);
  end

  assign load    = !out_valid || out_ready;
  assign done    = cur_valid && load && last;
  assign q_ready = !cur_valid || done;

  always_ff @(posedge clk) begin
    plane <= cfg.nx * cfg.ny;
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (q_valid && q_ready) begin
        cur_valid <= 1'b1;
        cur       <= q_entry;
      end else if (done) begin
        cur_valid <= 1'b0;
      end else if (cur_valid && load) begin
        cur.mask <= mask_next;
      end
      if (cur_valid && load) begin
        out_valid <= 1'b1;
        status    <= cur.status;
        is_last   <= last;
        neighbour_index <= (cur.status == lnig_pkg::ST_NEIGHBOUR) ? idx : '0;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[verif/tb_lattice_neighbour_index_generator_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_lattice_neighbour_index_generator_unit
// Self-checking bench: node indexes go in over valid/ready, every neighbour
// result is checked in order against a behavioral neighbour-list predictor.
// ---------------------------------------------------------------------------
module tb_lattice_neighbour_index_generator_unit;

  localparam int CYCLE_LIMIT  = 400000;  // far above the slowest legal run
  localparam int DRAIN_CYCLES = 60;      // slack after the last expected result
  localparam int SEGMENT_LEN  = 15;      // nodes per random lattice shape
  localparam int IDX_SPAN     = 1 << lnig_pkg::IDX_W;

  // one expected result transfer
  typedef struct {
    logic [lnig_pkg::IDX_W-1:0] idx;
    lnig_pkg::status_t          st;
    logic                       last;
  } neighbour_result_t;

  logic                           clk;
  logic                           rst;
  logic                           cfg_we;
  logic [lnig_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lnig_pkg::AXIS_W-1:0]    cfg_data;
  logic                           in_valid;
  logic                           in_ready;
  logic [lnig_pkg::IDX_W-1:0]     node_id;
  logic                           out_valid;
  logic                           out_ready;
  logic [lnig_pkg::IDX_W-1:0]     neighbour_index;
  logic [1:0]                     status;
  logic                           is_last;

  // shadow copy of the configuration registers, raw as written
  logic [lnig_pkg::AXIS_W-1:0] lat_nx;
  logic [lnig_pkg::AXIS_W-1:0] lat_ny;
  logic [lnig_pkg::AXIS_W-1:0] lat_nz;
  logic [1:0]                  lat_dims;
  logic                        lat_kind;

  neighbour_result_t pending_neighbours[$];
  int error_count   = 0;
  int send_idle_pct = 0;  // chance in 100 that the sender skips a cycle
  int recv_idle_pct = 0;  // chance in 100 that the receiver drops ready
  int hold_left     = 0;  // long receiver hold-off, counted down per cycle

  lattice_neighbour_index_generator_unit u_top (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .node_id         (node_id),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .neighbour_index (neighbour_index),
    .status          (status),
    .is_last         (is_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // register value as the block sees it: 0 behaves as 1, big values saturate
  function automatic int axis_span(input logic [lnig_pkg::AXIS_W-1:0] v);
    if (v == 0) return 1;
    if (v > lnig_pkg::MAX_ACROSS_DEF) return lnig_pkg::MAX_ACROSS_DEF;
    return int'(v);
  endfunction

  function automatic bit lattice_is_3d();
    return lat_dims == lnig_pkg::DIMS_3D;
  endfunction

  function automatic int lattice_nodes();
    int nz;
    nz = lattice_is_3d() ? axis_span(lat_nz) : 1;
    return axis_span(lat_nx) * axis_span(lat_ny) * nz;
  endfunction

  // append one expectation at the tail
  function automatic void queue_expect(input neighbour_result_t r);
    pending_neighbours.insert(pending_neighbours.size(), r);
  endfunction

  // Queue every result one node should produce: neighbours walked in
  // z, y, x order so indexes come out ascending; edge neighbours dropped.
  function automatic void predict_neighbours(input logic [lnig_pkg::IDX_W-1:0] node);
    int nx;
    int ny;
    int nz;
    int plane;
    int x;
    int y;
    int z;
    int hops;
    int count;
    bit three;
    bit von;
    logic [lnig_pkg::IDX_W-1:0] found [26];
    neighbour_result_t r;
    three = lattice_is_3d();
    von   = lat_kind;
    nx    = axis_span(lat_nx);
    ny    = axis_span(lat_ny);
    nz    = three ? axis_span(lat_nz) : 1;
    plane = nx * ny;
    count = 0;
    if (node >= lattice_nodes()) begin
      r = '{idx: '0, st: lnig_pkg::ST_PAST, last: 1'b1};
      queue_expect(r);
      return;
    end
    x = int'(node) % nx;
    y = (int'(node) / nx) % ny;
    z = int'(node) / plane;
    for (int dz = -1; dz <= 1; dz++) begin
      if ((!three && dz != 0) || z + dz < 0 || z + dz >= nz) continue;
      for (int dy = -1; dy <= 1; dy++) begin
        if (y + dy < 0 || y + dy >= ny) continue;
        for (int dx = -1; dx <= 1; dx++) begin
          hops = int'(dx != 0) + int'(dy != 0) + int'(dz != 0);
          if (hops == 0 || (von && hops != 1)) continue;
          if (x + dx < 0 || x + dx >= nx) continue;
          if (count < 26) begin
            found[count] = lnig_pkg::IDX_W'((x + dx) + nx * (y + dy) + plane * (z + dz));
            count++;
          end
        end
      end
    end
    if (count == 0) begin
      // single-node lattice
      r = '{idx: '0, st: lnig_pkg::ST_LONE, last: 1'b1};
      queue_expect(r);
      return;
    end
    for (int k = 0; k < count; k++) begin
      r = '{idx: found[k], st: lnig_pkg::ST_NEIGHBOUR, last: (k == count - 1)};
      queue_expect(r);
    end
  endfunction

  // ---------------------------------------------------------------------
  // Result checker: every output transfer against the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : check_result
    neighbour_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_neighbours.size() == 0) begin
        $display("%0t: unexpected result idx %0d status %0d last %0b",
                 $time, neighbour_index, status, is_last);
        error_count++;
      end else begin
        want = pending_neighbours.pop_front();
        if (neighbour_index !== want.idx) begin
          $display("%0t: neighbour_index expected %0d actual %0d",
                   $time, want.idx, neighbour_index);
          error_count++;
        end
        if (status !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, status);
          error_count++;
        end
        if (is_last !== want.last) begin
          $display("%0t: is_last expected %0b actual %0b", $time, want.last, is_last);
          error_count++;
        end
      end
    end
  end

  // Receiver: random ready, or held low for a long stretch on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------

  // Offer one node; valid stays up with a steady payload until the transfer.
  // The expectation is queued at the accepting edge.
  task automatic offer_node(input logic [lnig_pkg::IDX_W-1:0] node);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    node_id  <= node;
    do @(posedge clk); while (!in_ready);
    predict_neighbours(node);
  endtask

  // Drop valid, wait out every expected result plus pipeline slack.
  task automatic settle_lattice();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_neighbours.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write one register; only called with the block idle.
  task automatic write_reg(input lnig_pkg::cfg_reg_t which,
                           input logic [lnig_pkg::AXIS_W-1:0] v);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= which;
    cfg_data  <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (which)
      lnig_pkg::REG_NX:   lat_nx   = v;
      lnig_pkg::REG_NY:   lat_ny   = v;
      lnig_pkg::REG_NZ:   lat_nz   = v;
      lnig_pkg::REG_DIMS: lat_dims = v[1:0];
      lnig_pkg::REG_KIND: lat_kind = v[0];
      default: ;
    endcase
  endtask

  task automatic set_lattice(input logic [lnig_pkg::AXIS_W-1:0] nx,
                             input logic [lnig_pkg::AXIS_W-1:0] ny,
                             input logic [lnig_pkg::AXIS_W-1:0] nz,
                             input logic [lnig_pkg::AXIS_W-1:0] dims,
                             input logic [lnig_pkg::AXIS_W-1:0] kind);
    settle_lattice();
    write_reg(lnig_pkg::REG_NX, nx);
    write_reg(lnig_pkg::REG_NY, ny);
    write_reg(lnig_pkg::REG_NZ, nz);
    write_reg(lnig_pkg::REG_DIMS, dims);
    write_reg(lnig_pkg::REG_KIND, kind);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Reset shape is one node: lone-node status, everything else is past.
  task automatic test_reset_lattice();
    offer_node('0);
    offer_node(24'd1);
    offer_node('1);
  endtask

  // 5x4 Moore: corners, interior, last node and one past the end.
  task automatic test_moore_2d();
    set_lattice(9'd5, 9'd4, 9'd7, 9'd2, 9'd0);
    offer_node(24'd0);
    offer_node(24'd4);
    offer_node(24'd15);
    offer_node(24'd19);
    offer_node(24'd7);
    offer_node(24'd20);
  endtask

  // 3x3x3 von Neumann: center, corners, front face, back face, past.
  task automatic test_von_neumann_3d();
    set_lattice(9'd3, 9'd3, 9'd3, 9'd3, 9'd1);
    offer_node(24'd13);
    offer_node(24'd0);
    offer_node(24'd26);
    offer_node(24'd4);
    offer_node(24'd22);
    offer_node(24'd27);
  endtask

  // 3x3x3 Moore: full 26-neighbour center and both far corners.
  task automatic test_moore_3d();
    settle_lattice();
    write_reg(lnig_pkg::REG_KIND, 9'd0);
    offer_node(24'd13);
    offer_node(24'd0);
    offer_node(24'd26);
  endtask

  // Zero axis acts as one, oversized axis saturates, dimension codes
  // other than 3 mean 2D.
  task automatic test_axis_clamp();
    set_lattice(9'd0, 9'd511, 9'd0, 9'd1, 9'd0);
    offer_node(24'd0);
    offer_node(24'd255);
    offer_node(24'd256);
    set_lattice(9'd300, 9'd1, 9'd2, 9'd0, 9'd1);
    offer_node(24'd100);
  endtask

  // 256^3 fills the whole index range: top index is a real node.
  task automatic test_full_lattice();
    set_lattice(9'd256, 9'd256, 9'd256, 9'd3, 9'd0);
    offer_node('1);
    offer_node('0);
    offer_node(24'h7F7F7F);
  endtask

  // Receiver holds off for a long stretch while interior nodes keep
  // coming, so the queue fills and in_ready drops.
  task automatic test_backpressure();
    set_lattice(9'd4, 9'd4, 9'd4, 9'd3, 9'd0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left     = 500;
    for (int k = 0; k < 12; k++)
      offer_node(24'($urandom_range(1, 2) + 4 * $urandom_range(1, 2)
                     + 16 * $urandom_range(1, 2)));
  endtask

  function automatic logic [lnig_pkg::AXIS_W-1:0] random_axis();
    case ($urandom_range(19))
      0:       return 9'd0;
      1:       return 9'd256;
      2:       return 9'd511;
      3:       return 9'($urandom_range(257, 510));
      4:       return 9'($urandom_range(7, 255));
      default: return 9'($urandom_range(1, 6));
    endcase
  endfunction

  // Mostly in-lattice nodes; some past the end, some fully random.
  function automatic logic [lnig_pkg::IDX_W-1:0] random_node();
    int total;
    total = lattice_nodes();
    if ($urandom_range(99) < 8) return lnig_pkg::IDX_W'($urandom);
    if (total < IDX_SPAN && $urandom_range(99) < 10)
      return lnig_pkg::IDX_W'($urandom_range(IDX_SPAN - 1, total));
    return lnig_pkg::IDX_W'($urandom_range(total - 1, 0));
  endfunction

  task automatic test_random(input int sender_pct, input int receiver_pct,
                             input int items);
    logic [lnig_pkg::AXIS_W-1:0] dims;
    logic [lnig_pkg::AXIS_W-1:0] kind;
    send_idle_pct = sender_pct;
    recv_idle_pct = receiver_pct;
    for (int k = 0; k < items; k++) begin
      if (k % SEGMENT_LEN == 0) begin
        // unused upper data bits go in random on the narrow registers
        dims = {7'($urandom),
                2'($urandom_range(99) < 45 ? lnig_pkg::DIMS_3D : $urandom_range(3))};
        kind = {8'($urandom), 1'($urandom_range(1))};
        set_lattice(random_axis(), random_axis(), random_axis(), dims, kind);
      end
      offer_node(random_node());
    end
  endtask

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = lnig_pkg::REG_NX;
    cfg_data  = '0;
    in_valid  = 1'b0;
    node_id   = '0;
    lat_nx    = 9'd1;
    lat_ny    = 9'd1;
    lat_nz    = 9'd1;
    lat_dims  = 2'd2;
    lat_kind  = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send_idle_pct = 11;
    recv_idle_pct = 54;
    test_reset_lattice();
    test_moore_2d();
    test_von_neumann_3d();
    test_moore_3d();
    test_axis_clamp();
    test_full_lattice();
    test_backpressure();
    test_random(11, 54, 65);
    test_random(54, 11, 65);
    test_random(0, 0, 65);
    settle_lattice();

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[lattice_neighbour_index_generator_unit.f]
hw/rtl/lnig_pkg.sv
hw/rtl/lnig_front.sv
hw/rtl/lnig_queue.sv
hw/rtl/lnig_back.sv
hw/rtl/lattice_neighbour_index_generator_unit.sv
verif/tb_lattice_neighbour_index_generator_unit.sv
